// ----- sv/lpi_pkg.sv -----
// ----------------------------------------------------------------------------
// lpi_pkg
// Widths, payload types and helpers for the line/plane intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lpi_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_W      = 16;
   localparam int TOL_W       = 31;

   // squared lengths and square root
   localparam int SQ_W       = 2 * COORD_WIDTH;
   localparam int ROOT_W     = COORD_WIDTH;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int SQ_REM_W   = ROOT_W + 2;

   // normal scaling: |u| <= 1.0 in Q2.16
   localparam int UNIT_W     = FRAC_W + 2;
   localparam int NDIV_STEPS = UNIT_W - 1;
   localparam int NDIV_W     = COORD_WIDTH + FRAC_W;

   // dot products
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int DPD_W  = UNIT_W + COORD_WIDTH;
   localparam int DPN_W  = UNIT_W + DIFF_W;
   localparam int DEN_W  = DPD_W + 2;
   localparam int NUM_W  = DPN_W + 2;
   localparam int DENQ_W = DEN_W - FRAC_W;
   localparam int NUMQ_W = NUM_W - FRAC_W;

   // line parameter division
   localparam int TDIV_STEPS = COORD_WIDTH;
   localparam int TDIV_W     = DENQ_W + COORD_WIDTH;

   // point
   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int PQ_W   = PROD_W - FRAC_W;
   localparam int PT_W   = PQ_W + 1;

   localparam int BUF_DEPTH = 2;
   localparam int BUF_CNT_W = $clog2(BUF_DEPTH + 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [UNIT_W-1:0]      unit_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;

   typedef struct packed {
      unit_type x;
      unit_type y;
      unit_type z;
   } unit3_type;

   typedef struct packed {
      vec3_type o;
      vec3_type d;
      vec3_type p;
      vec3_type n;
      logic     ok;
   } geom_type;

   // what rides along the back half of the pipeline
   typedef struct packed {
      vec3_type o;
      vec3_type d;
      logic     ok;
      logic     par;
      logic     on;
      logic     neg;
   } track_type;

   typedef struct packed {
      logic      intersects;
      logic      is_parallel;
      logic      lies_on_plane;
      coord_type line_parameter;
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
   } res_type;

   // clamp a wide signed value to the coordinate range
   function automatic coord_type sat_pt(input logic signed [PT_W-1:0] v);
      logic hi_same;
      hi_same = (v[PT_W-1:COORD_WIDTH-1] == {(PT_W-COORD_WIDTH+1){v[PT_W-1]}});
      if (hi_same) begin
         return coord_type'(v[COORD_WIDTH-1:0]);
      end else if (v[PT_W-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// ----- sv/lpi_if.sv -----
// ----------------------------------------------------------------------------
// lpi_if
// Request, response and control-register channels of the intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpi_req_if;
   logic                 valid;
   logic                 ready;
   lpi_pkg::coord_type   line_origin_x;
   lpi_pkg::coord_type   line_origin_y;
   lpi_pkg::coord_type   line_origin_z;
   lpi_pkg::coord_type   line_direction_x;
   lpi_pkg::coord_type   line_direction_y;
   lpi_pkg::coord_type   line_direction_z;
   lpi_pkg::coord_type   plane_origin_x;
   lpi_pkg::coord_type   plane_origin_y;
   lpi_pkg::coord_type   plane_origin_z;
   lpi_pkg::coord_type   plane_normal_x;
   lpi_pkg::coord_type   plane_normal_y;
   lpi_pkg::coord_type   plane_normal_z;

   modport source (
      output valid, line_origin_x, line_origin_y, line_origin_z,
             line_direction_x, line_direction_y, line_direction_z,
             plane_origin_x, plane_origin_y, plane_origin_z,
             plane_normal_x, plane_normal_y, plane_normal_z,
      input  ready
   );
   modport sink (
      input  valid, line_origin_x, line_origin_y, line_origin_z,
             line_direction_x, line_direction_y, line_direction_z,
             plane_origin_x, plane_origin_y, plane_origin_z,
             plane_normal_x, plane_normal_y, plane_normal_z,
      output ready
   );
endinterface

interface lpi_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 intersects;
   logic                 is_parallel;
   logic                 lies_on_plane;
   lpi_pkg::coord_type   line_parameter;
   lpi_pkg::coord_type   point_x;
   lpi_pkg::coord_type   point_y;
   lpi_pkg::coord_type   point_z;

   modport source (
      output valid, intersects, is_parallel, lies_on_plane, line_parameter,
             point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, intersects, is_parallel, lies_on_plane, line_parameter,
             point_x, point_y, point_z,
      output ready
   );
endinterface

interface lpi_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lpi_pkg::TOL_W-1:0]   distance_tolerance;

   modport source (output valid, distance_tolerance, input ready);
   modport sink (input valid, distance_tolerance, output ready);
endinterface

`default_nettype wire

// ----- sv/lpi_sqrt.sv -----
// ----------------------------------------------------------------------------
// lpi_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [lpi_pkg::SQ_W-1:0]     in_rad,
   input  lpi_pkg::geom_type            in_geom,
   output logic                         out_valid,
   output logic [lpi_pkg::ROOT_W-1:0]   out_root,
   output lpi_pkg::geom_type            out_geom
);
   localparam int N     = lpi_pkg::SQRT_STEPS;
   localparam int SQ_W  = lpi_pkg::SQ_W;
   localparam int REM_W = lpi_pkg::SQ_REM_W;
   localparam int RT_W  = lpi_pkg::ROOT_W;

   logic                valid_ff [N];
   logic [SQ_W-1:0]     rad_ff   [N];
   logic [REM_W-1:0]    rem_ff   [N];
   logic [RT_W-1:0]     root_ff  [N];
   lpi_pkg::geom_type   geom_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                v_i;
      logic [SQ_W-1:0]     rad_i;
      logic [REM_W-1:0]    rem_i;
      logic [RT_W-1:0]     root_i;
      lpi_pkg::geom_type   geom_i;
      logic [REM_W-1:0]    rem_sh;
      logic [REM_W-1:0]    trial;
      logic                ge;
      logic [REM_W-1:0]    rem_in;
      logic [RT_W-1:0]     root_in;
      logic [SQ_W-1:0]     rad_in;

      if (k == 0) begin : g_first
         assign v_i    = in_valid;
         assign rad_i  = in_rad;
         assign rem_i  = '0;
         assign root_i = '0;
         assign geom_i = in_geom;
      end else begin : g_next
         assign v_i    = valid_ff[k-1];
         assign rad_i  = rad_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign geom_i = geom_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_i[REM_W-3:0], rad_i[SQ_W-1 -: 2]};
         trial   = {root_i, 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_i[RT_W-2:0], ge};
         rad_in  = {rad_i[SQ_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            geom_ff[k] <= geom_i;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_geom  = geom_ff[N-1];

endmodule

`default_nettype wire

// ----- sv/lpi_norm_div.sv -----
// ----------------------------------------------------------------------------
// lpi_norm_div
// Scales the plane normal to unit length: three restoring dividers in step.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_norm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [lpi_pkg::ROOT_W-1:0]   in_root,
   input  lpi_pkg::geom_type            in_geom,
   output logic                         out_valid,
   output lpi_pkg::unit3_type           out_unit,
   output lpi_pkg::geom_type            out_geom
);
   localparam int N     = lpi_pkg::NDIV_STEPS;
   localparam int W     = lpi_pkg::NDIV_W;
   localparam int Q_W   = lpi_pkg::NDIV_STEPS;
   localparam int RT_W  = lpi_pkg::ROOT_W;
   localparam int CW    = lpi_pkg::COORD_WIDTH;
   localparam int FW    = lpi_pkg::FRAC_W;
   localparam int UW    = lpi_pkg::UNIT_W;

   logic                  valid_ff [N];
   logic [2:0][W-1:0]     rem_ff   [N];
   logic [2:0][Q_W-1:0]   q_ff     [N];
   logic [RT_W-1:0]       root_ff  [N];
   lpi_pkg::geom_type     geom_ff  [N];

   lpi_pkg::coord_type    n_lane [3];
   logic [2:0][W-1:0]     rem_start;
   logic [2:0]            neg_out;
   logic [UW-1:0]         u_mag [3];
   logic [UW-1:0]         u_val [3];

   assign n_lane[0] = in_geom.n.x;
   assign n_lane[1] = in_geom.n.y;
   assign n_lane[2] = in_geom.n.z;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rem_start[l] = {(n_lane[l][CW-1] ? CW'(-n_lane[l]) : CW'(n_lane[l])), FW'(0)};
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam int B = N - 1 - k;
      logic                  v_i;
      logic [2:0][W-1:0]     rem_i;
      logic [2:0][Q_W-1:0]   q_i;
      logic [RT_W-1:0]       root_i;
      lpi_pkg::geom_type     geom_i;
      logic [W-1:0]          div_sh;
      logic [2:0]            ge;
      logic [2:0][W-1:0]     rem_in;
      logic [2:0][Q_W-1:0]   q_in;

      if (k == 0) begin : g_first
         assign v_i    = in_valid;
         assign rem_i  = rem_start;
         assign q_i    = '0;
         assign root_i = in_root;
         assign geom_i = in_geom;
      end else begin : g_next
         assign v_i    = valid_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign q_i    = q_ff[k-1];
         assign root_i = root_ff[k-1];
         assign geom_i = geom_ff[k-1];
      end

      always_comb begin
         div_sh = W'(root_i) << B;
         for (int l = 0; l < 3; l++) begin
            ge[l]     = (rem_i[l] >= div_sh);
            rem_in[l] = ge[l] ? (rem_i[l] - div_sh) : rem_i[l];
            q_in[l]   = {q_i[l][Q_W-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            root_ff[k] <= root_i;
            geom_ff[k] <= geom_i;
         end
      end
   end

   assign neg_out = {geom_ff[N-1].n.z[CW-1], geom_ff[N-1].n.y[CW-1], geom_ff[N-1].n.x[CW-1]};

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         u_mag[l] = {1'b0, q_ff[N-1][l]};
         u_val[l] = neg_out[l] ? (~u_mag[l] + UW'(1)) : u_mag[l];
      end
   end

   assign out_valid  = valid_ff[N-1];
   assign out_unit.x = lpi_pkg::unit_type'(u_val[0]);
   assign out_unit.y = lpi_pkg::unit_type'(u_val[1]);
   assign out_unit.z = lpi_pkg::unit_type'(u_val[2]);
   assign out_geom   = geom_ff[N-1];

endmodule

`default_nettype wire

// ----- sv/lpi_t_div.sv -----
// ----------------------------------------------------------------------------
// lpi_t_div
// Pipelined magnitude divider for the line parameter, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_t_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [lpi_pkg::NUM_W-1:0]         in_num_mag,
   input  logic [lpi_pkg::DENQ_W-1:0]        in_den_mag,
   input  lpi_pkg::track_type                in_trk,
   output logic                              out_valid,
   output logic [lpi_pkg::COORD_WIDTH-1:0]   out_quot,
   output logic                              out_ovf,
   output lpi_pkg::track_type                out_trk
);
   localparam int N   = lpi_pkg::TDIV_STEPS;
   localparam int NW  = lpi_pkg::NUM_W;
   localparam int DW  = lpi_pkg::DENQ_W;
   localparam int TW  = lpi_pkg::TDIV_W;
   localparam int CW  = lpi_pkg::COORD_WIDTH;

   // entry stage: quotient at or above 2^CW saturates regardless
   logic                 pre_valid_ff;
   logic [NW-1:0]        pre_num_ff;
   logic [DW-1:0]        pre_den_ff;
   logic                 pre_ovf_ff;
   lpi_pkg::track_type   pre_trk_ff;

   logic                 valid_ff [N];
   logic [NW-1:0]        rem_ff   [N];
   logic [DW-1:0]        den_ff   [N];
   logic [CW-1:0]        q_ff     [N];
   logic                 ovf_ff   [N];
   lpi_pkg::track_type   trk_ff   [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_num_ff <= in_num_mag;
         pre_den_ff <= in_den_mag;
         pre_ovf_ff <= (TW'(in_num_mag) >= {in_den_mag, CW'(0)});
         pre_trk_ff <= in_trk;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam int B = N - 1 - k;
      logic                 v_i;
      logic [NW-1:0]        rem_i;
      logic [DW-1:0]        den_i;
      logic [CW-1:0]        q_i;
      logic                 ovf_i;
      lpi_pkg::track_type   trk_i;
      logic [TW-1:0]        div_sh;
      logic [TW-1:0]        rem_wide;
      logic                 ge;
      logic [NW-1:0]        rem_in;
      logic [CW-1:0]        q_in;

      if (k == 0) begin : g_first
         assign v_i   = pre_valid_ff;
         assign rem_i = pre_num_ff;
         assign den_i = pre_den_ff;
         assign q_i   = '0;
         assign ovf_i = pre_ovf_ff;
         assign trk_i = pre_trk_ff;
      end else begin : g_next
         assign v_i   = valid_ff[k-1];
         assign rem_i = rem_ff[k-1];
         assign den_i = den_ff[k-1];
         assign q_i   = q_ff[k-1];
         assign ovf_i = ovf_ff[k-1];
         assign trk_i = trk_ff[k-1];
      end

      always_comb begin
         div_sh   = TW'(den_i) << B;
         rem_wide = TW'(rem_i);
         ge       = (rem_wide >= div_sh);
         rem_in   = ge ? NW'(rem_wide - div_sh) : rem_i;
         q_in     = {q_i[CW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_i;
            q_ff[k]   <= q_in;
            ovf_ff[k] <= ovf_i;
            trk_ff[k] <= trk_i;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quot  = q_ff[N-1];
   assign out_ovf   = ovf_ff[N-1];
   assign out_trk   = trk_ff[N-1];

endmodule

`default_nettype wire

// ----- sv/lpi_out_buf.sv -----
// ----------------------------------------------------------------------------
// lpi_out_buf
// Two-entry result buffer; holds the pipeline once both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module lpi_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lpi_pkg::res_type    push_res,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output lpi_pkg::res_type    out_res
);
   localparam int CNT_W = lpi_pkg::BUF_CNT_W;

   lpi_pkg::res_type   mem_ff [lpi_pkg::BUF_DEPTH];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               wr_ff;
   logic               rd_ff;
   logic               pop;

   assign out_valid = (cnt_ff != '0);
   assign room      = (cnt_ff != CNT_W'(lpi_pkg::BUF_DEPTH));
   assign pop       = out_valid && out_ready;
   assign out_res   = mem_ff[rd_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_res;
      end
   end

endmodule

`default_nettype wire

// ----- sv/line_plane_intersection_top.sv -----
// Pipeline: stages A to C, 32-stage square root, 17-stage normal scaling,
//   stages D to G, 33-stage parameter divider, stages H to J, result buffer.
// Throughput: one beat per cycle; req_ready drops only when both result
//   buffer entries are full.
// Reset: synchronous, clears all valid bits and the buffer; tolerance resets to 1.
// ----------------------------------------------------------------------------
// line_plane_intersection_top
// Q16.16 line/plane intersection, fully pipelined, one item per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module line_plane_intersection_top (
   input  logic        clock,
   input  logic        reset,
   lpi_req_if.sink     req_bus,
   lpi_rsp_if.source   rsp_bus,
   lpi_csr_if.sink     csr_bus
);
   localparam int CW     = lpi_pkg::COORD_WIDTH;
   localparam int FW     = lpi_pkg::FRAC_W;
   localparam int TW     = lpi_pkg::TOL_W;
   localparam int SQ_W   = lpi_pkg::SQ_W;
   localparam int DIFF_W = lpi_pkg::DIFF_W;
   localparam int DPD_W  = lpi_pkg::DPD_W;
   localparam int DPN_W  = lpi_pkg::DPN_W;
   localparam int DEN_W  = lpi_pkg::DEN_W;
   localparam int NUM_W  = lpi_pkg::NUM_W;
   localparam int DENQ_W = lpi_pkg::DENQ_W;
   localparam int NUMQ_W = lpi_pkg::NUMQ_W;
   localparam int PROD_W = lpi_pkg::PROD_W;
   localparam int PQ_W   = lpi_pkg::PQ_W;
   localparam int PT_W   = lpi_pkg::PT_W;

   logic adv;

   // control register
   logic [TW-1:0]     tol_ff;
   logic [2*TW-1:0]   tol2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= TW'(1);
         tol2_ff <= (2*TW)'(1);
      end else begin
         if (csr_bus.valid) begin
            tol_ff <= csr_bus.distance_tolerance;
         end
         tol2_ff <= tol_ff * tol_ff;
      end
   end

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = adv;

   // stage A: capture
   logic                a_v_ff;
   lpi_pkg::geom_type   a_geom_ff;
   lpi_pkg::geom_type   a_geom_in;

   always_comb begin
      a_geom_in.o.x = req_bus.line_origin_x;
      a_geom_in.o.y = req_bus.line_origin_y;
      a_geom_in.o.z = req_bus.line_origin_z;
      a_geom_in.d.x = req_bus.line_direction_x;
      a_geom_in.d.y = req_bus.line_direction_y;
      a_geom_in.d.z = req_bus.line_direction_z;
      a_geom_in.p.x = req_bus.plane_origin_x;
      a_geom_in.p.y = req_bus.plane_origin_y;
      a_geom_in.p.z = req_bus.plane_origin_z;
      a_geom_in.n.x = req_bus.plane_normal_x;
      a_geom_in.n.y = req_bus.plane_normal_y;
      a_geom_in.n.z = req_bus.plane_normal_z;
      a_geom_in.ok  = 1'b0;
   end

   // stage B: squares
   logic                     b_v_ff;
   lpi_pkg::geom_type        b_geom_ff;
   logic signed [SQ_W-1:0]   b_sq_ff [6];

   // stage C: squared lengths and validity
   logic                     c_v_ff;
   lpi_pkg::geom_type        c_geom_ff;
   logic [SQ_W-1:0]          c_nsq_ff;
   logic [SQ_W-1:0]          c_dsq_in;
   logic [SQ_W-1:0]          c_nsq_in;
   lpi_pkg::geom_type        c_geom_in;

   always_comb begin
      c_dsq_in     = SQ_W'(b_sq_ff[0]) + SQ_W'(b_sq_ff[1]) + SQ_W'(b_sq_ff[2]);
      c_nsq_in     = SQ_W'(b_sq_ff[3]) + SQ_W'(b_sq_ff[4]) + SQ_W'(b_sq_ff[5]);
      c_geom_in    = b_geom_ff;
      c_geom_in.ok = (c_dsq_in > SQ_W'(tol2_ff)) && (c_nsq_in > SQ_W'(tol2_ff));
   end

   // square root and normal scaling
   logic                          sq_v;
   logic [lpi_pkg::ROOT_W-1:0]    sq_root;
   lpi_pkg::geom_type             sq_geom;
   logic                          nd_v;
   lpi_pkg::unit3_type            nd_unit;
   lpi_pkg::geom_type             nd_geom;

   lpi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (c_v_ff),
      .in_rad    (c_nsq_ff),
      .in_geom   (c_geom_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_geom  (sq_geom)
   );

   lpi_norm_div u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_v),
      .in_root   (sq_root),
      .in_geom   (sq_geom),
      .out_valid (nd_v),
      .out_unit  (nd_unit),
      .out_geom  (nd_geom)
   );

   // stage D: dot product terms
   logic signed [DIFF_W-1:0]   dif [3];
   logic                       d_v_ff;
   logic signed [DPD_W-1:0]    d_pd_ff [3];
   logic signed [DPN_W-1:0]    d_pn_ff [3];
   lpi_pkg::track_type         d_trk_ff;
   lpi_pkg::track_type         d_trk_in;

   always_comb begin
      dif[0] = DIFF_W'($signed(nd_geom.p.x)) - DIFF_W'($signed(nd_geom.o.x));
      dif[1] = DIFF_W'($signed(nd_geom.p.y)) - DIFF_W'($signed(nd_geom.o.y));
      dif[2] = DIFF_W'($signed(nd_geom.p.z)) - DIFF_W'($signed(nd_geom.o.z));
      d_trk_in.o   = nd_geom.o;
      d_trk_in.d   = nd_geom.d;
      d_trk_in.ok  = nd_geom.ok;
      d_trk_in.par = 1'b0;
      d_trk_in.on  = 1'b0;
      d_trk_in.neg = 1'b0;
   end

   // stage E: sums
   logic                       e_v_ff;
   logic signed [DEN_W-1:0]    e_den_ff;
   logic signed [NUM_W-1:0]    e_num_ff;
   lpi_pkg::track_type         e_trk_ff;

   // stage F: truncate to Q16.16, numerator magnitude, quotient sign
   logic                       f_v_ff;
   logic signed [DENQ_W-1:0]   f_den_ff;
   logic signed [NUMQ_W-1:0]   f_num_ff;
   logic [NUM_W-1:0]           f_nmag_ff;
   lpi_pkg::track_type         f_trk_ff;
   logic [DEN_W-1:0]           den_adj;
   logic [NUM_W-1:0]           num_adj;
   lpi_pkg::track_type         f_trk_in;

   always_comb begin
      den_adj = e_den_ff + {{(DEN_W-FW){1'b0}}, {FW{e_den_ff[DEN_W-1]}}};
      num_adj = e_num_ff + {{(NUM_W-FW){1'b0}}, {FW{e_num_ff[NUM_W-1]}}};
      f_trk_in     = e_trk_ff;
      f_trk_in.neg = e_den_ff[DEN_W-1] ^ e_num_ff[NUM_W-1];
   end

   // stage G: parallel and on-plane tests
   logic                       g_v_ff;
   logic [NUM_W-1:0]           g_nmag_ff;
   logic [DENQ_W-1:0]          g_dmag_ff;
   lpi_pkg::track_type         g_trk_ff;
   logic [DENQ_W-1:0]          dmag;
   logic [NUMQ_W-1:0]          nqmag;
   lpi_pkg::track_type         g_trk_in;

   always_comb begin
      dmag  = f_den_ff[DENQ_W-1] ? DENQ_W'(-f_den_ff) : DENQ_W'(f_den_ff);
      nqmag = f_num_ff[NUMQ_W-1] ? NUMQ_W'(-f_num_ff) : NUMQ_W'(f_num_ff);
      g_trk_in     = f_trk_ff;
      g_trk_in.par = (dmag <= DENQ_W'(tol_ff));
      g_trk_in.on  = (nqmag <= NUMQ_W'(tol_ff));
   end

   // line parameter divider
   logic                  td_v;
   logic [CW-1:0]         td_q;
   logic                  td_ovf;
   lpi_pkg::track_type    td_trk;

   lpi_t_div u_t_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (g_v_ff),
      .in_num_mag (g_nmag_ff),
      .in_den_mag (g_dmag_ff),
      .in_trk     (g_trk_ff),
      .out_valid  (td_v),
      .out_quot   (td_q),
      .out_ovf    (td_ovf),
      .out_trk    (td_trk)
   );

   // stage H: signed, saturated t
   logic                  h_v_ff;
   lpi_pkg::coord_type    h_t_ff;
   lpi_pkg::track_type    h_trk_ff;
   lpi_pkg::coord_type    h_t_in;

   always_comb begin
      if (td_ovf) begin
         h_t_in = td_trk.neg ? lpi_pkg::COORD_MIN : lpi_pkg::COORD_MAX;
      end else if (td_trk.neg) begin
         h_t_in = (td_q > CW'(lpi_pkg::COORD_MIN)) ? lpi_pkg::COORD_MIN
                                                   : lpi_pkg::coord_type'(-td_q);
      end else begin
         h_t_in = td_q[CW-1] ? lpi_pkg::COORD_MAX : lpi_pkg::coord_type'(td_q);
      end
   end

   // stage I: t * d
   logic                       i_v_ff;
   lpi_pkg::coord_type         i_t_ff;
   lpi_pkg::track_type         i_trk_ff;
   logic signed [PROD_W-1:0]   i_prod_ff [3];

   // stage J: truncate products to Q16.16
   logic                       j_v_ff;
   lpi_pkg::coord_type         j_t_ff;
   lpi_pkg::track_type         j_trk_ff;
   logic signed [PQ_W-1:0]     j_pq_ff [3];
   logic [PROD_W-1:0]          prod_adj [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         prod_adj[l] = i_prod_ff[l] + {{(PROD_W-FW){1'b0}}, {FW{i_prod_ff[l][PROD_W-1]}}};
      end
   end

   // result assembly, written straight into the output buffer
   logic signed [PT_W-1:0]   pt [3];
   lpi_pkg::res_type         res;

   always_comb begin
      pt[0] = PT_W'($signed(j_trk_ff.o.x)) + PT_W'(j_pq_ff[0]);
      pt[1] = PT_W'($signed(j_trk_ff.o.y)) + PT_W'(j_pq_ff[1]);
      pt[2] = PT_W'($signed(j_trk_ff.o.z)) + PT_W'(j_pq_ff[2]);
      if (!j_trk_ff.ok) begin
         res = '0;
      end else if (j_trk_ff.par) begin
         res.intersects     = j_trk_ff.on;
         res.is_parallel    = 1'b1;
         res.lies_on_plane  = j_trk_ff.on;
         res.line_parameter = '0;
         res.point_x        = j_trk_ff.o.x;
         res.point_y        = j_trk_ff.o.y;
         res.point_z        = j_trk_ff.o.z;
      end else begin
         res.intersects     = 1'b1;
         res.is_parallel    = 1'b0;
         res.lies_on_plane  = 1'b0;
         res.line_parameter = j_t_ff;
         res.point_x        = lpi_pkg::sat_pt(pt[0]);
         res.point_y        = lpi_pkg::sat_pt(pt[1]);
         res.point_z        = lpi_pkg::sat_pt(pt[2]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_bus.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= nd_v;
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= td_v;
         i_v_ff <= h_v_ff;
         j_v_ff <= i_v_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_geom_ff  <= a_geom_in;

         b_geom_ff  <= a_geom_ff;
         b_sq_ff[0] <= SQ_W'($signed(a_geom_ff.d.x)) * SQ_W'($signed(a_geom_ff.d.x));
         b_sq_ff[1] <= SQ_W'($signed(a_geom_ff.d.y)) * SQ_W'($signed(a_geom_ff.d.y));
         b_sq_ff[2] <= SQ_W'($signed(a_geom_ff.d.z)) * SQ_W'($signed(a_geom_ff.d.z));
         b_sq_ff[3] <= SQ_W'($signed(a_geom_ff.n.x)) * SQ_W'($signed(a_geom_ff.n.x));
         b_sq_ff[4] <= SQ_W'($signed(a_geom_ff.n.y)) * SQ_W'($signed(a_geom_ff.n.y));
         b_sq_ff[5] <= SQ_W'($signed(a_geom_ff.n.z)) * SQ_W'($signed(a_geom_ff.n.z));

         c_geom_ff  <= c_geom_in;
         c_nsq_ff   <= c_nsq_in;

         d_trk_ff   <= d_trk_in;
         d_pd_ff[0] <= DPD_W'(nd_unit.x) * DPD_W'($signed(nd_geom.d.x));
         d_pd_ff[1] <= DPD_W'(nd_unit.y) * DPD_W'($signed(nd_geom.d.y));
         d_pd_ff[2] <= DPD_W'(nd_unit.z) * DPD_W'($signed(nd_geom.d.z));
         d_pn_ff[0] <= DPN_W'(nd_unit.x) * DPN_W'(dif[0]);
         d_pn_ff[1] <= DPN_W'(nd_unit.y) * DPN_W'(dif[1]);
         d_pn_ff[2] <= DPN_W'(nd_unit.z) * DPN_W'(dif[2]);

         e_trk_ff   <= d_trk_ff;
         e_den_ff   <= DEN_W'(d_pd_ff[0]) + DEN_W'(d_pd_ff[1]) + DEN_W'(d_pd_ff[2]);
         e_num_ff   <= NUM_W'(d_pn_ff[0]) + NUM_W'(d_pn_ff[1]) + NUM_W'(d_pn_ff[2]);

         f_trk_ff   <= f_trk_in;
         f_den_ff   <= DENQ_W'(den_adj[DEN_W-1:FW]);
         f_num_ff   <= NUMQ_W'(num_adj[NUM_W-1:FW]);
         f_nmag_ff  <= e_num_ff[NUM_W-1] ? NUM_W'(-e_num_ff) : NUM_W'(e_num_ff);

         g_trk_ff   <= g_trk_in;
         g_nmag_ff  <= f_nmag_ff;
         g_dmag_ff  <= dmag;

         h_t_ff     <= h_t_in;
         h_trk_ff   <= td_trk;

         i_t_ff       <= h_t_ff;
         i_trk_ff     <= h_trk_ff;
         i_prod_ff[0] <= PROD_W'(h_t_ff) * PROD_W'($signed(h_trk_ff.d.x));
         i_prod_ff[1] <= PROD_W'(h_t_ff) * PROD_W'($signed(h_trk_ff.d.y));
         i_prod_ff[2] <= PROD_W'(h_t_ff) * PROD_W'($signed(h_trk_ff.d.z));

         j_t_ff     <= i_t_ff;
         j_trk_ff   <= i_trk_ff;
         j_pq_ff[0] <= PQ_W'(prod_adj[0][PROD_W-1:FW]);
         j_pq_ff[1] <= PQ_W'(prod_adj[1][PROD_W-1:FW]);
         j_pq_ff[2] <= PQ_W'(prod_adj[2][PROD_W-1:FW]);
      end
   end

   // output buffer
   lpi_pkg::res_type out_res;

   lpi_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (adv && j_v_ff),
      .push_res  (res),
      .room      (adv),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_res   (out_res)
   );

   assign rsp_bus.intersects     = out_res.intersects;
   assign rsp_bus.is_parallel    = out_res.is_parallel;
   assign rsp_bus.lies_on_plane  = out_res.lies_on_plane;
   assign rsp_bus.line_parameter = out_res.line_parameter;
   assign rsp_bus.point_x        = out_res.point_x;
   assign rsp_bus.point_y        = out_res.point_y;
   assign rsp_bus.point_z        = out_res.point_z;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_plane_intersection_top. A local Q16.16 model
// predicts every ray/plane result. Random stalls on both channels, a long
// response hold-off, and several tolerance settings are exercised.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import lpi_pkg::*;

   typedef struct packed {
      vec3_type o;
      vec3_type d;
      vec3_type p;
      vec3_type n;
   } ray_type;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 120;

   logic clock;
   logic reset;

   lpi_req_if req_bus ();
   lpi_rsp_if rsp_bus ();
   lpi_csr_if csr_bus ();

   line_plane_intersection_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   res_type      hit_q[$];
   logic [30:0]  tol_cfg;
   int           fail_count;
   int           rsp_stall_left;
   int           rsp_hold_left;
   bit           rsp_idle_on;
   bit           req_idle_on;
   int           quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   function automatic longint sat_coord(longint x);
      if (x > longint'(COORD_MAX)) return longint'(COORD_MAX);
      if (x < longint'(COORD_MIN)) return longint'(COORD_MIN);
      return x;
   endfunction

   function automatic res_type predict_hit(ray_type r, logic [30:0] tol_raw);
      longint o[3], d[3], p[3], n[3], u[3];
      longint unsigned sd, sn, tol2, s, rt, bitv;
      longint tol, denf, numf, den, num, t;
      bit on;
      res_type e;
      e = '0;
      o = '{longint'(r.o.x), longint'(r.o.y), longint'(r.o.z)};
      d = '{longint'(r.d.x), longint'(r.d.y), longint'(r.d.z)};
      p = '{longint'(r.p.x), longint'(r.p.y), longint'(r.p.z)};
      n = '{longint'(r.n.x), longint'(r.n.y), longint'(r.n.z)};
      tol  = longint'({33'd0, tol_raw});
      tol2 = longint'(tol * tol);
      sd = longint'(d[0]*d[0]) + longint'(d[1]*d[1]) + longint'(d[2]*d[2]);
      sn = longint'(n[0]*n[0]) + longint'(n[1]*n[1]) + longint'(n[2]*n[2]);
      if (!(sd > tol2) || !(sn > tol2)) return e;
      // bitwise integer square root of |n|^2
      s = sn;
      rt = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= rt + bitv) begin
            s = s - (rt + bitv);
            rt = (rt >> 1) + bitv;
         end else begin
            rt = rt >> 1;
         end
         bitv = bitv >> 2;
      end
      denf = 0;
      numf = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = (n[i] * 65536) / longint'(rt);
         denf += u[i] * d[i];
         numf += u[i] * (p[i] - o[i]);
      end
      den = denf / 65536;
      num = numf / 65536;
      if ((den < 0 ? -den : den) <= tol) begin
         on = (num < 0 ? -num : num) <= tol;
         e.intersects    = on;
         e.is_parallel   = 1'b1;
         e.lies_on_plane = on;
         e.point_x = r.o.x;
         e.point_y = r.o.y;
         e.point_z = r.o.z;
         return e;
      end
      t = sat_coord(numf / den);
      e.intersects     = 1'b1;
      e.line_parameter = coord_type'(t);
      e.point_x = coord_type'(sat_coord(o[0] + (t * d[0]) / 65536));
      e.point_y = coord_type'(sat_coord(o[1] + (t * d[1]) / 65536));
      e.point_z = coord_type'(sat_coord(o[2] + (t * d[2]) / 65536));
      return e;
   endfunction

   // -------------------------------------------------------------- drivers
   function automatic int pick_gap();
      if (!req_idle_on || $urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_ray(ray_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.line_origin_x    <= r.o.x;
      req_bus.line_origin_y    <= r.o.y;
      req_bus.line_origin_z    <= r.o.z;
      req_bus.line_direction_x <= r.d.x;
      req_bus.line_direction_y <= r.d.y;
      req_bus.line_direction_z <= r.d.z;
      req_bus.plane_origin_x   <= r.p.x;
      req_bus.plane_origin_y   <= r.p.y;
      req_bus.plane_origin_z   <= r.p.z;
      req_bus.plane_normal_x   <= r.n.x;
      req_bus.plane_normal_y   <= r.n.y;
      req_bus.plane_normal_z   <= r.n.z;
      do @(posedge clock); while (!req_bus.ready);
      hit_q.push_back(predict_hit(r, tol_cfg));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (hit_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [30:0] value);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_bus.valid              <= 1'b1;
      csr_bus.distance_tolerance <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      tol_cfg = value;
   endtask

   // ------------------------------------------------------------ stimulus
   function automatic coord_type rnd_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
         2: return coord_type'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         default: begin
            case ($urandom_range(0, 3))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return coord_type'(0);
               default: return coord_type'(-1);
            endcase
         end
      endcase
   endfunction

   function automatic vec3_type rnd_vec(int mode);
      vec3_type v;
      v.x = rnd_coord(mode);
      v.y = rnd_coord(mode);
      v.z = rnd_coord(mode);
      return v;
   endfunction

   // well-formed crossings, parallel lines (on and off plane) and noise
   function automatic ray_type rnd_ray();
      ray_type r;
      int kind;
      coord_type a, b;
      kind = $urandom_range(0, 9);
      r.o = rnd_vec(2);
      r.p = rnd_vec(2);
      r.d = rnd_vec(1);
      r.n = rnd_vec(1);
      if (kind == 6 || kind == 7) begin
         a = rnd_coord(1);
         b = rnd_coord(1);
         r.n = '{a, b, coord_type'(0)};
         r.d = '{-b, a, rnd_coord(1)};
         if (kind == 7) r.p = '{r.o.x - b, r.o.y + a, r.o.z + rnd_coord(1)};
      end else if (kind == 8) begin
         r = {rnd_vec(0), rnd_vec(0), rnd_vec(0), rnd_vec(0)};
      end else if (kind == 9) begin
         r = {rnd_vec($urandom_range(0, 3)), rnd_vec($urandom_range(0, 3)),
              rnd_vec($urandom_range(0, 3)), rnd_vec($urandom_range(0, 3))};
      end
      return r;
   endfunction

   function automatic ray_type mk_ray(vec3_type o, vec3_type d, vec3_type p, vec3_type n);
      return {o, d, p, n};
   endfunction

   task automatic test_directed();
      vec3_type zero, one_x, one_z, big;
      zero  = '{32'sd0, 32'sd0, 32'sd0};
      one_x = '{32'sh0001_0000, 32'sd0, 32'sd0};
      one_z = '{32'sd0, 32'sd0, 32'sh0001_0000};
      big   = '{COORD_MAX, COORD_MAX, COORD_MAX};
      send_ray(mk_ray(zero, zero, zero, one_z));                      // zero direction
      send_ray(mk_ray(zero, one_z, zero, zero));                      // zero normal
      send_ray(mk_ray(zero, one_z, '{0, 0, 32'sh0003_0000}, one_z));  // plain crossing
      send_ray(mk_ray(zero, one_x, zero, one_z));                     // parallel on plane
      send_ray(mk_ray(zero, one_x, one_z, one_z));                    // parallel off plane
      send_ray(mk_ray(zero, '{0, 0, 32'sd2}, big, one_z));            // huge t, saturates
      send_ray(mk_ray(big, big, '{COORD_MIN, COORD_MIN, COORD_MIN}, big));
      send_ray(mk_ray('{COORD_MIN, COORD_MIN, COORD_MIN}, '{COORD_MIN, COORD_MIN, COORD_MIN},
                      big, '{COORD_MIN, COORD_MIN, COORD_MIN}));
      send_ray(mk_ray(big, '{0, 0, -32'sd1}, zero, '{0, 0, COORD_MIN}));
      send_ray(mk_ray(zero, '{32'sd1, 0, 0}, one_z, '{0, 0, 32'sd1}));  // tiny vectors
      send_ray(mk_ray(zero, '{32'sd2, 0, 0}, one_z, '{0, 0, 32'sd2}));
      send_ray(mk_ray(zero, '{-32'sh1_0000, 0, 32'sh1_0000}, '{0, 0, -32'sh5_0000}, one_z));
      send_ray(mk_ray(big, '{COORD_MAX, 0, 32'sd1}, zero, one_x));
      send_ray(mk_ray('{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}));
   endtask

   task automatic test_random(int count);
      repeat (count) send_ray(rnd_ray());
   endtask

   task automatic test_back_to_back();
      req_idle_on = 0;
      rsp_idle_on = 0;
      test_random(150);
      req_idle_on = 1;
      rsp_idle_on = 1;
   endtask

   task automatic test_backpressure();
      rsp_hold_left = 400;    // receiver holds off while the sender keeps going
      req_idle_on = 0;
      test_random(200);
      req_idle_on = 1;
      drain_results();        // sender waits until everything came back
      test_random(20);
   endtask

   task automatic test_tolerance_sweep();
      write_tolerance(31'd0);
      test_directed();
      test_random(120);
      write_tolerance(31'h0001_0000);
      test_directed();
      test_random(120);
      write_tolerance(31'h7FFF_FFFF);
      test_directed();
      test_random(40);
      write_tolerance(31'($urandom_range(0, 2000)));
      test_random(120);
      write_tolerance(31'd1);
   endtask

   initial begin
      reset = 1'b1;
      clock = 1'b0;
      fail_count = 0;
      tol_cfg = 31'd1;
      rsp_stall_left = 0;
      rsp_hold_left = 0;
      rsp_idle_on = 1;
      req_idle_on = 1;
      req_bus.valid <= 1'b0;
      req_bus.line_origin_x <= '0;
      req_bus.line_origin_y <= '0;
      req_bus.line_origin_z <= '0;
      req_bus.line_direction_x <= '0;
      req_bus.line_direction_y <= '0;
      req_bus.line_direction_z <= '0;
      req_bus.plane_origin_x <= '0;
      req_bus.plane_origin_y <= '0;
      req_bus.plane_origin_z <= '0;
      req_bus.plane_normal_x <= '0;
      req_bus.plane_normal_y <= '0;
      req_bus.plane_normal_z <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.distance_tolerance <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_back_to_back();
      test_backpressure();
      test_tolerance_sweep();
      test_random(200);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && hit_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------ response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(0, 2);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      res_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.intersects, rsp_bus.is_parallel, rsp_bus.lies_on_plane,
                 rsp_bus.line_parameter, rsp_bus.point_x, rsp_bus.point_y, rsp_bus.point_z};
         if (hit_q.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
         end else begin
            want = hit_q.pop_front();
            if (got.intersects !== want.intersects) begin
               $error("intersects exp %0d got %0d", want.intersects, got.intersects);
               fail_count++;
            end
            if (got.is_parallel !== want.is_parallel) begin
               $error("is_parallel exp %0d got %0d", want.is_parallel, got.is_parallel);
               fail_count++;
            end
            if (got.lies_on_plane !== want.lies_on_plane) begin
               $error("lies_on_plane exp %0d got %0d", want.lies_on_plane,
                      got.lies_on_plane);
               fail_count++;
            end
            if (got.line_parameter !== want.line_parameter) begin
               $error("line_parameter exp %0d got %0d", want.line_parameter,
                      got.line_parameter);
               fail_count++;
            end
            if (got.point_x !== want.point_x) begin
               $error("point_x exp %0d got %0d", want.point_x, got.point_x);
               fail_count++;
            end
            if (got.point_y !== want.point_y) begin
               $error("point_y exp %0d got %0d", want.point_y, got.point_y);
               fail_count++;
            end
            if (got.point_z !== want.point_z) begin
               $error("point_z exp %0d got %0d", want.point_z, got.point_z);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready) || (!req_bus.valid && hit_q.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

`default_nettype wire
